// ----- hdl/visited_path_stack_cycle_check_macros.svh -----
// Assertion macros for the path stack block.
`ifndef VISITED_PATH_STACK_CYCLE_CHECK_MACROS_SVH
`define VISITED_PATH_STACK_CYCLE_CHECK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VPSC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/vpsc_pkg.sv -----
`default_nettype none

package vpsc_pkg;

   localparam int STACK_DEPTH = 1024;
   localparam int REF_BITS    = 48;

   localparam int LIMIT_W  = 11;
   localparam int DEPTH_W  = 11;
   localparam int STATUS_W = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   localparam int COUNT_W   = $clog2(STACK_DEPTH + 1);
   localparam int LANE_SPAN = 2 ** $clog2(STACK_DEPTH);
   localparam int LANES     = (LANE_SPAN < 32) ? LANE_SPAN : 32;
   localparam int LANE_W    = $clog2(LANES);
   localparam int ROWS      = (STACK_DEPTH + LANES - 1) / LANES;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ROW_CNT_W = $clog2(ROWS + 1);
   localparam int CMP_W     = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;

   typedef enum logic {
      OP_ENTER = 1'b0,
      OP_EXIT  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ENTERED = 3'd0,
      ST_NULL    = 3'd1,
      ST_CYCLE   = 3'd2,
      ST_LIMIT   = 3'd3,
      ST_EXITED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- hdl/vpsc_if.sv -----
`default_nettype none

interface vpsc_req_if;
   logic                             valid;
   logic                             ready;
   vpsc_pkg::op_type                 op;
   logic [vpsc_pkg::REF_BITS-1:0]    object_ref;

   modport source (output valid, output op, output object_ref, input ready);
   modport sink   (input valid, input op, input object_ref, output ready);
endinterface

interface vpsc_rsp_if;
   logic                             valid;
   logic                             ready;
   vpsc_pkg::status_type             status;
   logic [vpsc_pkg::DEPTH_W-1:0]     path_depth;

   modport source (output valid, output status, output path_depth, input ready);
   modport sink   (input valid, input status, input path_depth, output ready);
endinterface

`default_nettype wire

// ----- hdl/visited_path_stack_cycle_check.sv -----
// Path stack with cycle detection. Each request either enters an object
// reference (pushed unless it is null, already on the path, or the path is at
// the depth limit) or exits the current object (pops one entry if any); every
// request yields exactly one response with a status and the path depth after
// it. The path is held in a memory of rows of 32 references; an enter request
// reads one row per cycle through the single row read port and compares it
// against the reference, stopping early when a cycle is found. Exit and null
// requests skip the scan and go from idle straight to the response state. One
// request is worked on at a time; a finished response waits in its output
// register while the next request is taken.
// depth_limit may be changed only while idle and saturates at the stack size.
`default_nettype none
`include "visited_path_stack_cycle_check_macros.svh"

module visited_path_stack_cycle_check (
   input  wire logic                        clock,
   input  wire logic                        reset,
   vpsc_req_if.sink                         req_chan,
   vpsc_rsp_if.source                       rsp_chan,
   input  wire logic                        csr_wr_en,
   input  wire logic [vpsc_pkg::LIMIT_W-1:0] csr_wr_data
);

   localparam int REF_BITS  = vpsc_pkg::REF_BITS;
   localparam int COUNT_W   = vpsc_pkg::COUNT_W;
   localparam int LANES     = vpsc_pkg::LANES;
   localparam int LANE_W    = vpsc_pkg::LANE_W;
   localparam int ROWS      = vpsc_pkg::ROWS;
   localparam int ROW_W     = vpsc_pkg::ROW_W;
   localparam int ROW_CNT_W = vpsc_pkg::ROW_CNT_W;
   localparam int CMP_W     = vpsc_pkg::CMP_W;
   localparam int DEPTH_W   = vpsc_pkg::DEPTH_W;
   localparam int LIMIT_W   = vpsc_pkg::LIMIT_W;

   vpsc_pkg::state_type        state_ff, state_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [LIMIT_W-1:0]         limit_ff;
   logic [REF_BITS-1:0]        ref_ff, ref_in;
   logic [ROW_CNT_W-1:0]       row_ff, row_in;
   logic                       pend_ff, pend_in;
   logic [ROW_W-1:0]           pend_row_ff, pend_row_in;
   vpsc_pkg::status_type       res_status_ff, res_status_in;
   logic [DEPTH_W-1:0]         res_depth_ff, res_depth_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   vpsc_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic [DEPTH_W-1:0]         rsp_depth_ff, rsp_depth_in;

   logic [REF_BITS-1:0]        path_mem_ff [ROWS][LANES];
   logic [REF_BITS-1:0]        rd_row_ff [LANES];

   logic [COUNT_W:0]           nrows_sum;
   logic [ROW_CNT_W-1:0]       nrows;
   logic [COUNT_W-1:0]         full_rows;
   logic                       row_full;
   logic [LANES-1:0]           lane_match;
   logic                       hit;
   logic                       issue;
   logic [ROW_W-1:0]           rd_addr;
   logic                       wr_en;
   logic [ROW_W-1:0]           wr_row;
   logic [LANE_W-1:0]          wr_lane;
   logic [CMP_W-1:0]           lim_ext;
   logic [CMP_W-1:0]           stack_ext;
   logic [CMP_W-1:0]           eff_lim;
   logic                       at_limit;

   // Scan bookkeeping: rows holding live entries, and the live lanes of a row.
   assign nrows_sum = {1'b0, count_ff} + (COUNT_W + 1)'(LANES - 1);
   assign nrows     = ROW_CNT_W'(nrows_sum >> LANE_W);
   assign full_rows = count_ff >> LANE_W;
   assign row_full  = COUNT_W'(pend_row_ff) < full_rows;
   assign rd_addr   = ROW_W'(row_ff);

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_match[l] = (row_full || (LANE_W'(l) < count_ff[LANE_W-1:0]))
                         && (rd_row_ff[l] == ref_ff);
      end
   end

   assign hit   = pend_ff && (|lane_match);
   assign issue = (state_ff == vpsc_pkg::S_SCAN) && (row_ff < nrows) && !hit;

   assign lim_ext   = CMP_W'(limit_ff);
   assign stack_ext = CMP_W'(vpsc_pkg::STACK_DEPTH);
   assign eff_lim   = (lim_ext > stack_ext) ? stack_ext : lim_ext;
   assign at_limit  = CMP_W'(count_ff) >= eff_lim;

   assign wr_row  = ROW_W'(count_ff >> LANE_W);
   assign wr_lane = count_ff[LANE_W-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ref_in        = ref_ff;
      row_in        = row_ff;
      pend_in       = 1'b0;
      pend_row_in   = pend_row_ff;
      res_status_in = res_status_ff;
      res_depth_in  = res_depth_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      wr_en         = 1'b0;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         vpsc_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               if (req_chan.op == vpsc_pkg::OP_EXIT) begin
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
                  res_status_in = vpsc_pkg::ST_EXITED;
                  res_depth_in  = DEPTH_W'(count_in);
                  state_in      = vpsc_pkg::S_RESP;
               end else if (req_chan.object_ref == '0) begin
                  res_status_in = vpsc_pkg::ST_NULL;
                  res_depth_in  = DEPTH_W'(count_ff);
                  state_in      = vpsc_pkg::S_RESP;
               end else begin
                  ref_in   = req_chan.object_ref;
                  row_in   = '0;
                  state_in = vpsc_pkg::S_SCAN;
               end
            end
         end
         vpsc_pkg::S_SCAN: begin
            if (hit) begin
               res_status_in = vpsc_pkg::ST_CYCLE;
               res_depth_in  = DEPTH_W'(count_ff);
               state_in      = vpsc_pkg::S_RESP;
            end else if (issue) begin
               row_in      = row_ff + 1'b1;
               pend_in     = 1'b1;
               pend_row_in = rd_addr;
            end else if (!pend_ff) begin
               state_in = vpsc_pkg::S_DECIDE;
            end
         end
         vpsc_pkg::S_DECIDE: begin
            if (at_limit) begin
               res_status_in = vpsc_pkg::ST_LIMIT;
               res_depth_in  = DEPTH_W'(count_ff);
            end else begin
               wr_en         = 1'b1;
               count_in      = count_ff + 1'b1;
               res_status_in = vpsc_pkg::ST_ENTERED;
               res_depth_in  = DEPTH_W'(count_in);
            end
            state_in = vpsc_pkg::S_RESP;
         end
         vpsc_pkg::S_RESP: begin
            // Hand over once the output register is free or being drained.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_depth_in  = res_depth_ff;
               state_in      = vpsc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = vpsc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vpsc_pkg::S_IDLE;
         count_ff     <= '0;
         limit_ff     <= vpsc_pkg::LIMIT_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ref_ff        <= ref_in;
      row_ff        <= row_in;
      pend_row_ff   <= pend_row_in;
      res_status_ff <= res_status_in;
      res_depth_ff  <= res_depth_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   // Path memory: one lane write, one registered row read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         path_mem_ff[wr_row][wr_lane] <= ref_ff;
      end
      if (issue) begin
         rd_row_ff <= path_mem_ff[rd_addr];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.path_depth = rsp_depth_ff;

   `VPSC_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= COUNT_W'(vpsc_pkg::STACK_DEPTH), "path count above stack size")
   `VPSC_ASSERT_NEXT(a_exit_pops, req_chan.valid && req_chan.ready && req_chan.op == vpsc_pkg::OP_EXIT && count_ff != '0, count_ff == $past(count_ff) - 1'b1, "exit did not pop")
   `VPSC_ASSERT_NOW(a_scan_rows, state_ff == vpsc_pkg::S_SCAN, row_ff <= nrows, "scan ran past live rows")
   `VPSC_ASSERT_NOW(a_pend_in_scan, pend_ff, state_ff == vpsc_pkg::S_SCAN, "row read pending outside scan")

endmodule

`default_nettype wire

// ----- test/vpsc_path_checker.sv -----
module vpsc_path_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   vpsc_req_if                               req_mon,
   vpsc_rsp_if                               rsp_mon,
   input  wire logic                         csr_wr_en,
   input  wire logic [vpsc_pkg::LIMIT_W-1:0] csr_wr_data,
   output int unsigned                       requests_seen,
   output int unsigned                       responses_seen,
   output int unsigned                       error_count,
   output int unsigned                       cycle_hits,
   output int unsigned                       limit_hits,
   output int unsigned                       deepest_path
);
   timeunit 1ns;
   timeprecision 1ps;
   import vpsc_pkg::*;

   typedef struct packed {
      status_type           status;
      logic [DEPTH_W-1:0]   depth;
   } path_outcome;

   logic [REF_BITS-1:0] path_refs [0:STACK_DEPTH-1];
   int unsigned         path_len;
   logic [LIMIT_W-1:0]  path_cap;
   path_outcome         awaited_outcomes [$];

   // Apply one request to the shadow path and return the response it must give.
   function automatic path_outcome step_path(op_type op, logic [REF_BITS-1:0] oref);
      path_outcome r;
      logic        on_path;
      int unsigned cap;
      on_path = 1'b0;
      cap = (path_cap > STACK_DEPTH) ? STACK_DEPTH : path_cap;
      if (op == OP_EXIT) begin
         if (path_len > 0) path_len--;
         r.status = ST_EXITED;
      end else if (oref == '0) begin
         r.status = ST_NULL;
      end else begin
         for (int i = 0; i < path_len; i++) begin
            if (path_refs[i] == oref) on_path = 1'b1;
         end
         if (on_path) begin
            r.status = ST_CYCLE;
            cycle_hits++;
         end else if (path_len >= cap) begin
            r.status = ST_LIMIT;
            limit_hits++;
         end else begin
            path_refs[path_len] = oref;
            path_len++;
            r.status = ST_ENTERED;
            if (path_len > deepest_path) deepest_path = path_len;
         end
      end
      r.depth = DEPTH_W'(path_len);
      return r;
   endfunction

   always @(posedge clock) begin
      path_outcome want;
      int unsigned bad;
      bad = 0;
      if (reset) begin
         path_len = 0;
         path_cap = LIMIT_RESET;
         awaited_outcomes.delete();
         cycle_hits = 0;
         limit_hits = 0;
         deepest_path = 0;
         requests_seen <= 0;
         responses_seen <= 0;
         error_count <= 0;
      end else begin
         if (csr_wr_en) path_cap = csr_wr_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            responses_seen <= responses_seen + 1;
            if (awaited_outcomes.size() == 0) begin
               $display("%0t: response with none awaited, status %0d depth %0d",
                        $time, rsp_mon.status, rsp_mon.path_depth);
               bad++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_mon.status);
                  bad++;
               end
               if (rsp_mon.path_depth !== want.depth) begin
                  $display("%0t: path_depth expected %0d actual %0d",
                           $time, want.depth, rsp_mon.path_depth);
                  bad++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            requests_seen <= requests_seen + 1;
            awaited_outcomes.push_back(step_path(req_mon.op, req_mon.object_ref));
         end
         if (bad != 0) error_count <= error_count + bad;
      end
   end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import vpsc_pkg::*;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;
   logic               steady;

   int unsigned requests_seen;
   int unsigned responses_seen;
   int unsigned error_count;
   int unsigned cycle_hits;
   int unsigned limit_hits;
   int unsigned deepest_path;

   logic [REF_BITS-1:0] ref_log [0:2047];
   int unsigned         ref_count;

   vpsc_req_if req_bus ();
   vpsc_rsp_if rsp_bus ();

   visited_path_stack_cycle_check dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   vpsc_path_checker path_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .requests_seen  (requests_seen),
      .responses_seen (responses_seen),
      .error_count    (error_count),
      .cycle_hits     (cycle_hits),
      .limit_hits     (limit_hits),
      .deepest_path   (deepest_path)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #6_000_000;
      $display("tb_top failed");
      $finish;
   end

   // Response side: random stalls, one long hold-off once 400 requests have been seen.
   initial begin
      int unsigned hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && requests_seen >= 400) begin
            hold_left = 400;
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
         end else if (steady) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= 30);
         end
      end
   end

   task automatic send_request(input op_type op, input logic [REF_BITS-1:0] oref);
      while (!steady && $urandom_range(0, 99) < 30) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.object_ref <= oref;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (op == OP_ENTER && oref != '0) begin
         if (ref_count < 2048) begin
            ref_log[ref_count] = oref;
            ref_count++;
         end else begin
            ref_log[$urandom_range(0, 2047)] = oref;
         end
      end
   endtask

   // Drop valid and hold until every response has been taken.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (requests_seen != responses_seen) @(posedge clock);
   endtask

   task automatic write_depth_limit(input logic [LIMIT_W-1:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [REF_BITS-1:0] pick_ref(input int unsigned repeat_pct);
      logic [63:0] raw;
      int unsigned roll;
      raw = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if (roll < 4) return '0;
      if (roll < 4 + repeat_pct && ref_count > 0)
         return ref_log[$urandom_range(0, ref_count - 1)];
      return raw[REF_BITS-1:0];
   endfunction

   task automatic random_request(input int unsigned enter_pct, input int unsigned repeat_pct);
      if ($urandom_range(0, 99) < enter_pct)
         send_request(OP_ENTER, pick_ref(repeat_pct));
      else
         send_request(OP_EXIT, pick_ref(50));
   endtask

   initial begin
      logic [LIMIT_W-1:0] phase_caps [0:5];
      req_bus.valid <= 1'b0;
      req_bus.op <= OP_ENTER;
      req_bus.object_ref <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      steady <= 1'b0;
      reset <= 1'b1;
      ref_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Default limit: empty exits, null, cycle on the widest reference.
      send_request(OP_EXIT, 48'h0000_0000_0ABC);
      send_request(OP_ENTER, '0);
      send_request(OP_ENTER, '1);
      send_request(OP_ENTER, '1);
      send_request(OP_ENTER, 48'h0000_0000_0001);
      send_request(OP_ENTER, '0);
      send_request(OP_ENTER, 48'h0000_0000_0001);
      send_request(OP_EXIT, '1);
      send_request(OP_EXIT, '0);
      send_request(OP_EXIT, 48'h8000_0000_0000);

      // Zero limit refuses every fresh reference, null still wins.
      write_depth_limit(11'd0);
      send_request(OP_ENTER, 48'h0000_0000_0005);
      send_request(OP_ENTER, '0);
      send_request(OP_EXIT, '0);

      // Full path: cycle and null are tested ahead of the depth check.
      write_depth_limit(11'd2);
      send_request(OP_ENTER, 48'hAAAA_AAAA_AAAA);
      send_request(OP_ENTER, 48'h5555_5555_5555);
      send_request(OP_ENTER, 48'h8000_0000_0000);
      send_request(OP_ENTER, 48'hAAAA_AAAA_AAAA);
      send_request(OP_ENTER, '0);
      send_request(OP_EXIT, '0);
      send_request(OP_EXIT, '0);

      // Limit above the stack size saturates: fill the whole path.
      write_depth_limit(11'h7FF);
      for (int i = 0; i < 1300; i++) begin
         if (i == 700) wait_drained();
         if (i == 900) steady <= 1'b1;
         if (i == 1100) steady <= 1'b0;
         random_request(98, 6);
      end

      phase_caps[0] = 11'd1;
      phase_caps[1] = 11'd3;
      phase_caps[2] = 11'd0;
      phase_caps[3] = 11'd1024;
      phase_caps[4] = LIMIT_W'($urandom_range(0, 2047));
      phase_caps[5] = LIMIT_W'($urandom_range(0, 2047));
      for (int p = 0; p < 6; p++) begin
         write_depth_limit(phase_caps[p]);
         for (int i = 0; i < 55; i++) random_request(45, 30);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      $display("Ran %0d requests and %0d responses over ten depth-limit settings;",
               requests_seen, responses_seen);
      $display("deepest path %0d, %0d cycle refusals, %0d depth-limit refusals.",
               deepest_path, cycle_hits, limit_hits);
      if (error_count == 0 && requests_seen == responses_seen) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/vpsc_pkg.sv
hdl/vpsc_if.sv
hdl/visited_path_stack_cycle_check.sv
test/vpsc_path_checker.sv
test/tb_top.sv
